// ===== hdl/fud_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_pkg
// Shared types, character constants and hex helpers for the form-urlencoded
// decoder.
// ----------------------------------------------------------------------------
package fud_pkg;

    localparam int MaxRes = 3;
    localparam int CountW = 2;

    localparam logic [7:0] CHR_EQ    = 8'h3D;
    localparam logic [7:0] CHR_AMP   = 8'h26;
    localparam logic [7:0] CHR_PLUS  = 8'h2B;
    localparam logic [7:0] CHR_PCT   = 8'h25;
    localparam logic [7:0] CHR_SPACE = 8'h20;
    localparam logic [7:0] CHR_ZERO  = 8'h30;
    localparam logic [7:0] CHR_NINE  = 8'h39;
    localparam logic [7:0] CHR_HEX_A = 8'd65;
    localparam logic [7:0] CHR_HEX_F = 8'd70;

    typedef enum logic [1:0] {
        MODE_KEY   = 2'd0,
        MODE_VALUE = 2'd1,
        MODE_ERROR = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        PH_NONE  = 2'd0,
        PH_PCT   = 2'd1,
        PH_DIGIT = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        KIND_KEY   = 2'd0,
        KIND_VALUE = 2'd1,
        KIND_PAIR  = 2'd2,
        KIND_ERROR = 2'd3
    } kind_t;

    typedef struct packed {
        logic [CountW-1:0]          count;
        logic [MaxRes-1:0][1:0]     kinds;
        logic [MaxRes-1:0][7:0]     bytes;
    } res_bundle_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= CHR_ZERO) && (c <= CHR_NINE)) ||
               ((c >= CHR_HEX_A) && (c <= CHR_HEX_F));
    endfunction

    function automatic logic [3:0] hex_nibble(input logic [7:0] c);
        if (c <= CHR_NINE) begin
            return c[3:0];
        end
        return c[3:0] + 4'd9;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/fud_step.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_step
// Parser state registers and the single-pass decode of one item into a
// bundle of up to three results.
// ----------------------------------------------------------------------------
module fud_step import fud_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        accept,
    input  wire logic        op,
    input  wire logic [7:0]  char_byte,
    output res_bundle_t      bundle
);

    mode_t       mode_reg, mode_next;
    phase_t      phase_reg, phase_next;
    logic [7:0]  held_reg, held_next;
    res_bundle_t flush_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_KEY;
            phase_reg <= PH_NONE;
            held_reg  <= '0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            held_reg  <= held_next;
        end
    end

    // A pending escape is flushed literally before the pair-complete mark.
    always_comb begin
        flush_b = '0;
        case (phase_reg)
            PH_PCT: begin
                flush_b.kinds[0] = KIND_VALUE;
                flush_b.bytes[0] = CHR_PCT;
                flush_b.kinds[1] = KIND_PAIR;
                flush_b.count    = 2'd2;
            end
            PH_DIGIT: begin
                flush_b.kinds[0] = KIND_VALUE;
                flush_b.bytes[0] = CHR_PCT;
                flush_b.kinds[1] = KIND_VALUE;
                flush_b.bytes[1] = held_reg;
                flush_b.kinds[2] = KIND_PAIR;
                flush_b.count    = 2'd3;
            end
            default: begin
                flush_b.kinds[0] = KIND_PAIR;
                flush_b.count    = 2'd1;
            end
        endcase
    end

    always_comb begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        held_next  = held_reg;
        bundle     = '0;
        if (op) begin
            if (mode_reg == MODE_KEY || mode_reg == MODE_VALUE) begin
                bundle = flush_b;
            end
            mode_next  = MODE_KEY;
            phase_next = PH_NONE;
            held_next  = '0;
        end else begin
            case (mode_reg)
                MODE_KEY: begin
                    if (char_byte == CHR_EQ) begin
                        mode_next = MODE_VALUE;
                    end else begin
                        bundle.kinds[0] = KIND_KEY;
                        bundle.bytes[0] = char_byte;
                        bundle.count    = 2'd1;
                    end
                end
                MODE_VALUE: begin
                    if (char_byte == CHR_AMP) begin
                        bundle     = flush_b;
                        mode_next  = MODE_KEY;
                        phase_next = PH_NONE;
                        held_next  = '0;
                    end else if (phase_reg == PH_NONE) begin
                        if (char_byte == CHR_PCT) begin
                            phase_next = PH_PCT;
                        end else begin
                            bundle.kinds[0] = KIND_VALUE;
                            bundle.bytes[0] = (char_byte == CHR_PLUS) ? CHR_SPACE
                                                                       : char_byte;
                            bundle.count    = 2'd1;
                        end
                    end else if (!is_hex(char_byte)) begin
                        bundle.kinds[0] = KIND_ERROR;
                        bundle.count    = 2'd1;
                        mode_next       = MODE_ERROR;
                        phase_next      = PH_NONE;
                        held_next       = '0;
                    end else if (phase_reg == PH_PCT) begin
                        held_next  = char_byte;
                        phase_next = PH_DIGIT;
                    end else begin
                        bundle.kinds[0] = KIND_VALUE;
                        bundle.bytes[0] = {hex_nibble(held_reg), hex_nibble(char_byte)};
                        bundle.count    = 2'd1;
                        phase_next      = PH_NONE;
                        held_next       = '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    a_escape_in_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg != PH_NONE) |-> (mode_reg == MODE_VALUE))
        else $error("escape pending outside value mode");

    a_end_resets: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && op) |=> (mode_reg == MODE_KEY && phase_reg == PH_NONE))
        else $error("end of string did not return to key mode");

endmodule
`default_nettype wire

// ===== hdl/fud_outbuf.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// fud_outbuf
// Result register that holds one bundle and hands its results out one item
// per cycle while m_ready is high, shifting the remaining ones forward.
// ----------------------------------------------------------------------------
module fud_outbuf import fud_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        load,
    input  wire res_bundle_t bundle,
    output logic             free,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_out_byte,
    output logic             m_out_last
);

    res_bundle_t buf_reg, buf_next;
    logic        m_fire;

    assign m_fire     = m_valid && m_ready;
    assign m_valid    = (buf_reg.count != '0);
    assign free       = (buf_reg.count == '0) || ((buf_reg.count == 2'd1) && m_ready);
    assign m_out_kind = buf_reg.kinds[0];
    assign m_out_byte = buf_reg.bytes[0];
    assign m_out_last = (buf_reg.count == 2'd1);

    always_comb begin
        buf_next = buf_reg;
        if (load) begin
            buf_next = bundle;
        end else if (m_fire) begin
            buf_next.count = buf_reg.count - 2'd1;
            buf_next.kinds = {2'b00, buf_reg.kinds[MaxRes-1:1]};
            buf_next.bytes = {8'h00, buf_reg.bytes[MaxRes-1:1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg <= '0;
        end else begin
            buf_reg <= buf_next;
        end
    end

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> ((buf_reg.count == '0) || (buf_reg.count == 2'd1 && m_ready)))
        else $error("bundle loaded over pending results");

    a_more_follow: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_fire && buf_reg.count > 2'd1) |=> m_valid)
        else $error("remaining results lost");

    a_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_out_kind == KIND_PAIR || m_out_kind == KIND_ERROR))
            |-> (m_out_byte == 8'h00))
        else $error("nonzero byte on mark or error");

endmodule
`default_nettype wire

// ===== hdl/form_urlencoded_decoder.sv =====
// ----------------------------------------------------------------------------
// form_urlencoded_decoder
// The first result of an item is registered and valid in the cycle after acceptance.
// Throughput: one item per cycle while each item yields at most one result and
// m_ready is high; an item that yields several results holds the result register until its last one is taken.
// Reset: synchronous active-low aresetn returns to key mode with no escape.
// ----------------------------------------------------------------------------
`default_nettype none
module form_urlencoded_decoder import fud_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_op,
    input  wire logic [7:0]  s_char_byte,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_out_kind,
    output logic [7:0]       m_out_byte,
    output logic             m_out_last
);

    logic        accept;
    logic        free;
    res_bundle_t bundle;

    assign s_ready = free;
    assign accept  = s_valid && s_ready;

    fud_step u_step (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .op        (s_op),
        .char_byte (s_char_byte),
        .bundle    (bundle)
    );

    fud_outbuf u_outbuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .bundle     (bundle),
        .free       (free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_kind (m_out_kind),
        .m_out_byte (m_out_byte),
        .m_out_last (m_out_last)
    );

endmodule
`default_nettype wire

// ===== tb/sv/form_urlencoded_decoder_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// form_urlencoded_decoder_test
// Feeds parameter strings to the decoder one byte per item and checks every
// key byte, value byte, pair mark and error result against a local decoder
// model. A directed pass hits escapes, flushes and error recovery; random
// strings then run under several idle and stall patterns, including a long
// receiver hold-off that backs the block up.
// ----------------------------------------------------------------------------
module form_urlencoded_decoder_test;
    import fud_pkg::*;

    typedef struct {
        logic       op;
        logic [7:0] data;
    } char_item_t;

    typedef struct {
        kind_t      kind;
        logic [7:0] data;
        logic       last;
    } result_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_op = 1'b0;
    logic [7:0] s_char_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic [1:0] m_out_kind;
    logic [7:0] m_out_byte;
    logic       m_out_last;

    char_item_t pending_chars[$];
    result_t    due_results[$];
    int         mismatches = 0;
    int         tx_idle_pct = 0;
    int         rx_stall_pct = 0;
    logic       rx_hold = 1'b0;

    mode_t      dec_mode = MODE_KEY;
    phase_t     dec_phase = PH_NONE;
    logic [7:0] dec_held = 8'h00;

    form_urlencoded_decoder u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_op        (s_op),
        .s_char_byte (s_char_byte),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_kind  (m_out_kind),
        .m_out_byte  (m_out_byte),
        .m_out_last  (m_out_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= CHR_ZERO && c <= CHR_NINE) begin
            return int'(c - CHR_ZERO);
        end
        if (c >= CHR_HEX_A && c <= CHR_HEX_F) begin
            return int'(c - CHR_HEX_A) + 10;
        end
        return -1;
    endfunction

    function automatic void emit(input kind_t kind, input logic [7:0] data);
        result_t r;
        r.kind = kind;
        r.data = data;
        r.last = 1'b0;
        due_results.insert(due_results.size(), r);
    endfunction

    function automatic void flush_escape();
        if (dec_phase == PH_PCT) begin
            emit(KIND_VALUE, CHR_PCT);
        end else if (dec_phase == PH_DIGIT) begin
            emit(KIND_VALUE, CHR_PCT);
            emit(KIND_VALUE, dec_held);
        end
        dec_phase = PH_NONE;
        dec_held = 8'h00;
    endfunction

    function automatic void decode_char(input logic op, input logic [7:0] c);
        int first;
        int lo;
        int hi;
        first = due_results.size();
        lo = hex_digit(c);
        if (op) begin
            if (dec_mode != MODE_ERROR) begin
                flush_escape();
                emit(KIND_PAIR, 8'h00);
            end
            dec_mode = MODE_KEY;
            dec_phase = PH_NONE;
            dec_held = 8'h00;
        end else if (dec_mode == MODE_KEY) begin
            if (c == CHR_EQ) begin
                dec_mode = MODE_VALUE;
            end else begin
                emit(KIND_KEY, c);
            end
        end else if (dec_mode == MODE_VALUE) begin
            if (c == CHR_AMP) begin
                flush_escape();
                emit(KIND_PAIR, 8'h00);
                dec_mode = MODE_KEY;
            end else if (dec_phase == PH_NONE) begin
                if (c == CHR_PLUS) begin
                    emit(KIND_VALUE, CHR_SPACE);
                end else if (c == CHR_PCT) begin
                    dec_phase = PH_PCT;
                end else begin
                    emit(KIND_VALUE, c);
                end
            end else if (lo < 0) begin
                emit(KIND_ERROR, 8'h00);
                dec_mode = MODE_ERROR;
                dec_phase = PH_NONE;
                dec_held = 8'h00;
            end else if (dec_phase == PH_PCT) begin
                dec_held = c;
                dec_phase = PH_DIGIT;
            end else begin
                hi = hex_digit(dec_held);
                emit(KIND_VALUE, 8'((hi << 4) | lo));
                dec_phase = PH_NONE;
                dec_held = 8'h00;
            end
        end
        if (due_results.size() > first) begin
            due_results[due_results.size() - 1].last = 1'b1;
        end
    endfunction

    // Driver: presents queued items and predicts each one as it is accepted.
    always @(posedge aclk) begin
        char_item_t it;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                decode_char(s_op, s_char_byte);
            end
            if (!s_valid || s_ready) begin
                if (pending_chars.size() > 0 &&
                    $urandom_range(0, 99) >= tx_idle_pct) begin
                    it = pending_chars.pop_front();
                    s_valid <= 1'b1;
                    s_op <= it.op;
                    s_char_byte <= it.data;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each accepted result against the oldest prediction.
    always @(posedge aclk) begin
        result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (due_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("unexpected result: kind %0d byte %02h last %0b",
                                 m_out_kind, m_out_byte, m_out_last);
                    end
                end else begin
                    want = due_results.pop_front();
                    if (m_out_kind !== want.kind || m_out_byte !== want.data ||
                        m_out_last !== want.last) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("mismatch: expected kind %0d byte %02h last %0b, %s",
                                     want.kind, want.data, want.last, "got:");
                            $display("          actual   kind %0d byte %02h last %0b",
                                     m_out_kind, m_out_byte, m_out_last);
                        end
                    end
                end
            end
            m_ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    function automatic void push_byte(input logic [7:0] c);
        char_item_t it;
        it.op = 1'b0;
        it.data = c;
        pending_chars.insert(pending_chars.size(), it);
    endfunction

    function automatic void push_end();
        char_item_t it;
        it.op = 1'b1;
        it.data = 8'($urandom_range(1, 255));
        pending_chars.insert(pending_chars.size(), it);
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] hex_char();
        int v;
        v = $urandom_range(0, 15);
        return (v < 10) ? 8'(CHR_ZERO + v) : 8'(CHR_HEX_A + v - 10);
    endfunction

    // One random pair; a string holding a broken escape is always closed.
    function automatic void push_random_pair();
        int   r;
        logic broken;
        broken = 1'b0;
        repeat ($urandom_range(0, 3)) push_byte(any_byte());
        if ($urandom_range(0, 9) != 0) begin
            push_byte(CHR_EQ);
            repeat ($urandom_range(0, 5)) begin
                r = $urandom_range(0, 99);
                if (r < 40) begin
                    push_byte(any_byte());
                end else if (r < 55) begin
                    push_byte(CHR_PLUS);
                end else if (r < 85) begin
                    push_byte(CHR_PCT);
                    push_byte(hex_char());
                    push_byte(hex_char());
                end else if (r < 93) begin
                    push_byte(CHR_PCT);
                    if ($urandom_range(0, 1)) begin
                        push_byte(hex_char());
                    end
                    broken = 1'b1;
                end else begin
                    push_byte(CHR_PCT);
                    push_byte(any_byte());
                    broken = 1'b1;
                end
            end
        end
        if (broken || $urandom_range(0, 2) == 0) begin
            push_end();
        end else begin
            push_byte(CHR_AMP);
        end
    endfunction

    task automatic push_random_items(input int count);
        int target;
        target = pending_chars.size() + count;
        while (pending_chars.size() < target) begin
            push_random_pair();
        end
        push_end();
    endtask

    task automatic wait_drained();
        while (pending_chars.size() != 0 || s_valid || due_results.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic hold_receiver(input int cycles);
        rx_hold = 1'b1;
        repeat (cycles) @(negedge aclk);
        rx_hold = 1'b0;
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed: empty string, key extremes, escapes, flushes, errors.
        push_end();
        push_byte(8'h01);
        push_byte(8'hFF);
        push_byte(CHR_AMP);
        push_byte(CHR_EQ);
        push_byte(CHR_EQ);
        push_byte(CHR_PLUS);
        push_byte(CHR_PCT);
        push_byte(8'h34);
        push_byte(8'h46);
        push_byte(CHR_PCT);
        push_byte(CHR_HEX_A);
        push_byte(CHR_AMP);
        push_byte(CHR_EQ);
        push_byte(CHR_PCT);
        push_end();
        push_byte(CHR_EQ);
        push_byte(CHR_PCT);
        push_byte(8'h61);
        push_byte(8'h78);
        push_end();
        push_byte(CHR_EQ);
        push_byte(CHR_PCT);
        push_byte(CHR_PCT);
        push_end();
        wait_drained();

        // Receiver holds off while the sender keeps offering items.
        push_random_items(12);
        fork
            hold_receiver(200);
        join_none
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 80; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 80; end
                default: begin tx_idle_pct = 11; rx_stall_pct = 11; end
            endcase
            push_random_items(15);
            wait_drained();
        end

        repeat (10) @(negedge aclk);
        if (mismatches == 0) begin
            $display("[form_urlencoded_decoder] OK");
        end else begin
            $display("[form_urlencoded_decoder] ERROR");
        end
        $finish;
    end

    initial begin
        #(2_000_000);
        $display("[form_urlencoded_decoder] ERROR");
        $finish;
    end

endmodule
